### rtl/core/imu_fus_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fus_pkg
// Shared types and constants of the inertial burst unpack and scale core.
// ----------------------------------------------------------------------------
package imu_fus_pkg;

   localparam int unsigned FrameLen = 14;
   localparam int unsigned PosW     = 4;

   localparam logic [7:0] AllOnes  = 8'hFF;
   localparam logic [7:0] AllZeros = 8'h00;

   typedef logic [PosW-1:0]    pos_type;
   typedef logic [7:0]         byte_type;
   typedef logic signed [15:0] count_type;

   // accel: x1000 then round by shift of 14
   localparam int unsigned AccNumW  = 25;
   localparam int unsigned AccShift = 14;
   localparam logic [AccNumW-1:0] AccMul  = AccNumW'(1000);
   localparam logic [AccNumW-1:0] AccHalf = AccNumW'(16384 / 2);

   // gyro: x100, plus half of 131, then reciprocal multiply
   localparam int unsigned GyrNumW   = 22;
   localparam int unsigned GyrShift  = 30;
   localparam int unsigned GyrRecipW = 23;
   localparam longint unsigned GyrDen = 131;
   localparam logic [GyrNumW-1:0] GyrMul  = GyrNumW'(100);
   localparam logic [GyrNumW-1:0] GyrHalf = GyrNumW'(GyrDen / 2);
   localparam logic [GyrRecipW-1:0] GyrRecip =
      GyrRecipW'(((64'd1 << GyrShift) + GyrDen - 64'd1) / GyrDen);
   localparam int unsigned GyrProdW = GyrNumW + GyrRecipW;

   // temperature: x10000, plus half of 33387, reciprocal multiply, offset
   localparam int unsigned TmpNumW   = 29;
   localparam int unsigned TmpShift  = 45;
   localparam int unsigned TmpRecipW = 30;
   localparam longint unsigned TmpDen = 33387;
   localparam logic [TmpNumW-1:0] TmpMul  = TmpNumW'(10000);
   localparam logic [TmpNumW-1:0] TmpHalf = TmpNumW'(TmpDen / 2);
   localparam logic [TmpRecipW-1:0] TmpRecip =
      TmpRecipW'(((64'd1 << TmpShift) + TmpDen - 64'd1) / TmpDen);
   localparam int unsigned TmpProdW = TmpNumW + TmpRecipW;

   typedef logic signed [11:0] accel_type;
   typedef logic signed [15:0] gyro_type;
   typedef logic signed [14:0] temp_type;

   localparam temp_type TmpOffset = temp_type'(2100);

   typedef struct packed {
      logic                dead;
      count_type [2:0]     accel;
      count_type           temp;
      count_type [2:0]     gyro;
   } frame_type;

   typedef struct packed {
      logic                dead;
      accel_type [2:0]     accel;
      gyro_type  [2:0]     gyro;
      temp_type            temp;
   } result_type;

endpackage

### rtl/core/imu_fus_collect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fus_collect
// Byte position tracking, burst store and AND/OR accumulators; registers the
// assembled burst on its last byte.
// ----------------------------------------------------------------------------
module imu_fus_collect (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   byte_vld,
   input  imu_fus_pkg::byte_type  data_byte,
   input  logic                   frame_start,
   output logic                   frame_vld,
   output imu_fus_pkg::frame_type frame
);
   import imu_fus_pkg::*;

   byte_type  store_ff [FrameLen];
   pos_type   pos_ff, pos_in;
   byte_type  and_ff, and_in;
   byte_type  or_ff, or_in;
   logic      frame_vld_ff, frame_vld_in;
   frame_type frame_ff, frame_in;

   pos_type   pos_raw;
   pos_type   pos_cur;
   byte_type  and_cur;
   byte_type  or_cur;
   logic      last_byte;
   logic      take;

   assign take = byte_vld && advance;

   always_comb begin
      pos_raw   = frame_start ? '0 : pos_ff;
      pos_cur   = (pos_raw >= PosW'(FrameLen)) ? '0 : pos_raw;
      and_cur   = (frame_start ? AllOnes : and_ff) & data_byte;
      or_cur    = (frame_start ? AllZeros : or_ff) | data_byte;
      last_byte = (pos_cur == PosW'(FrameLen - 1));
   end

   always_comb begin
      pos_in = pos_ff;
      and_in = and_ff;
      or_in  = or_ff;
      if (take) begin
         if (last_byte) begin
            pos_in = '0;
            and_in = AllOnes;
            or_in  = AllZeros;
         end else begin
            pos_in = pos_cur + 1'b1;
            and_in = and_cur;
            or_in  = or_cur;
         end
      end
   end

   always_comb begin
      frame_vld_in      = take && last_byte;
      frame_in.dead     = (and_cur == AllOnes) || (or_cur == AllZeros);
      frame_in.accel[0] = {store_ff[0], store_ff[1]};
      frame_in.accel[1] = {store_ff[2], store_ff[3]};
      frame_in.accel[2] = {store_ff[4], store_ff[5]};
      frame_in.temp     = {store_ff[6], store_ff[7]};
      frame_in.gyro[0]  = {store_ff[8], store_ff[9]};
      frame_in.gyro[1]  = {store_ff[10], store_ff[11]};
      frame_in.gyro[2]  = {store_ff[12], data_byte};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         and_ff       <= AllOnes;
         or_ff        <= AllZeros;
         frame_vld_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         and_ff <= and_in;
         or_ff  <= or_in;
         if (advance) begin
            frame_vld_ff <= frame_vld_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         store_ff[pos_cur] <= data_byte;
      end
      if (advance) begin
         frame_ff <= frame_in;
      end
   end

   assign frame_vld = frame_vld_ff;
   assign frame     = frame_ff;

endmodule

### rtl/core/imu_fus_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fus_scale
// Scaling pipeline: magnitude and numerator, reciprocal multiply, then sign,
// offset and dead-bus masking into the result register.
// ----------------------------------------------------------------------------
module imu_fus_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    frame_vld,
   input  imu_fus_pkg::frame_type  frame,
   output logic                    result_vld,
   output imu_fus_pkg::result_type result
);
   import imu_fus_pkg::*;

   function automatic logic [15:0] magnitude(input count_type value);
      logic [15:0] raw;
      raw = 16'(value);
      return raw[15] ? 16'(-raw) : raw;
   endfunction

   // numerator stage
   logic               num_vld_ff, num_vld_in;
   logic               num_dead_ff, num_dead_in;
   logic [2:0]         acc_neg_ff, acc_neg_in;
   logic [2:0]         gyr_neg_ff, gyr_neg_in;
   logic               tmp_neg_ff, tmp_neg_in;
   logic [AccNumW-1:0] acc_num_ff [3];
   logic [AccNumW-1:0] acc_num_in [3];
   logic [GyrNumW-1:0] gyr_num_ff [3];
   logic [GyrNumW-1:0] gyr_num_in [3];
   logic [TmpNumW-1:0] tmp_num_ff, tmp_num_in;

   // product stage
   logic                prd_vld_ff, prd_vld_in;
   logic                prd_dead_ff;
   logic [2:0]          prd_acc_neg_ff;
   logic [2:0]          prd_gyr_neg_ff;
   logic                prd_tmp_neg_ff;
   logic [10:0]         acc_q_ff [3];
   logic [10:0]         acc_q_in [3];
   logic [GyrProdW-1:0] gyr_prod_ff [3];
   logic [GyrProdW-1:0] gyr_prod_in [3];
   logic [TmpProdW-1:0] tmp_prod_ff, tmp_prod_in;

   // result stage
   logic       result_vld_ff;
   result_type result_ff, result_in;

   logic [14:0] gyr_q [3];
   logic [13:0] tmp_q;
   temp_type    tmp_signed;

   always_comb begin
      num_vld_in  = frame_vld;
      num_dead_in = frame.dead;
      for (int i = 0; i < 3; i++) begin
         acc_neg_in[i] = frame.accel[i][15];
         gyr_neg_in[i] = frame.gyro[i][15];
         acc_num_in[i] = AccNumW'(magnitude(frame.accel[i])) * AccMul + AccHalf;
         gyr_num_in[i] = GyrNumW'(magnitude(frame.gyro[i])) * GyrMul + GyrHalf;
      end
      tmp_neg_in = frame.temp[15];
      tmp_num_in = TmpNumW'(magnitude(frame.temp)) * TmpMul + TmpHalf;
   end

   always_comb begin
      prd_vld_in = num_vld_ff;
      for (int i = 0; i < 3; i++) begin
         acc_q_in[i]    = acc_num_ff[i][AccNumW-1:AccShift];
         gyr_prod_in[i] = GyrProdW'(gyr_num_ff[i]) * GyrProdW'(GyrRecip);
      end
      tmp_prod_in = TmpProdW'(tmp_num_ff) * TmpProdW'(TmpRecip);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         gyr_q[i] = gyr_prod_ff[i][GyrShift +: 15];
      end
      tmp_q      = tmp_prod_ff[TmpShift +: 14];
      tmp_signed = prd_tmp_neg_ff ? temp_type'(-{1'b0, tmp_q}) : temp_type'({1'b0, tmp_q});
      result_in  = '0;
      result_in.dead = prd_dead_ff;
      if (!prd_dead_ff) begin
         for (int i = 0; i < 3; i++) begin
            result_in.accel[i] = prd_acc_neg_ff[i] ? accel_type'(-{1'b0, acc_q_ff[i]})
                                                   : accel_type'({1'b0, acc_q_ff[i]});
            result_in.gyro[i]  = prd_gyr_neg_ff[i] ? gyro_type'(-{1'b0, gyr_q[i]})
                                                   : gyro_type'({1'b0, gyr_q[i]});
         end
         result_in.temp = tmp_signed + TmpOffset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vld_ff    <= 1'b0;
         prd_vld_ff    <= 1'b0;
         result_vld_ff <= 1'b0;
      end else if (advance) begin
         num_vld_ff    <= num_vld_in;
         prd_vld_ff    <= prd_vld_in;
         result_vld_ff <= prd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_dead_ff    <= num_dead_in;
         acc_neg_ff     <= acc_neg_in;
         gyr_neg_ff     <= gyr_neg_in;
         tmp_neg_ff     <= tmp_neg_in;
         acc_num_ff     <= acc_num_in;
         gyr_num_ff     <= gyr_num_in;
         tmp_num_ff     <= tmp_num_in;
         prd_dead_ff    <= num_dead_ff;
         prd_acc_neg_ff <= acc_neg_ff;
         prd_gyr_neg_ff <= gyr_neg_ff;
         prd_tmp_neg_ff <= tmp_neg_ff;
         acc_q_ff       <= acc_q_in;
         gyr_prod_ff    <= gyr_prod_in;
         tmp_prod_ff    <= tmp_prod_in;
         result_ff      <= result_in;
      end
   end

   assign result_vld = result_vld_ff;
   assign result     = result_ff;

endmodule

### rtl/core/imu_frame_unpack_and_scale_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_unpack_and_scale_core
// Collects a 14-byte inertial sensor data block and returns accel in milli-g,
// gyro in centi-degrees per second and die temperature in centi-degrees C.
// ----------------------------------------------------------------------------
// One byte is taken per clock while req_tready is high. Bytes are counted
// into a 14-byte burst; a byte with req_tuser high restarts the burst at its
// first byte and drops any partial one. The 14th byte yields one result
// transfer after the burst register, the numerator stage, the reciprocal
// multiply stage and the result register; other bytes yield nothing. All
// stages advance together, so the whole pipeline stalls only while a result
// waits on rsp_tready. A burst of all 0xFF or all 0x00 bytes returns
// rsp_tuser high with every value zero. Divisions round half away from zero.
// ----------------------------------------------------------------------------
module imu_frame_unpack_and_scale_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // frame_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // accel_x_mg, accel_y_mg, accel_z_mg,
                                     // gyro_x_cdps, gyro_y_cdps, gyro_z_cdps,
                                     // temp_centi_c, zero pad
   output logic         rsp_tuser    // bus_dead
);
   import imu_fus_pkg::*;

   logic       advance;
   logic       frame_vld;
   frame_type  frame;
   logic       result_vld;
   result_type result;

   assign advance    = !result_vld || rsp_tready;
   assign req_tready = advance;

   imu_fus_collect u_collect (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .byte_vld    (req_tvalid),
      .data_byte   (req_tdata),
      .frame_start (req_tuser),
      .frame_vld   (frame_vld),
      .frame       (frame)
   );

   imu_fus_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .frame_vld  (frame_vld),
      .frame      (frame),
      .result_vld (result_vld),
      .result     (result)
   );

   assign rsp_tvalid = result_vld;
   assign rsp_tuser  = result.dead;
   assign rsp_tdata  = {5'b0, result.temp,
                        result.gyro[2], result.gyro[1], result.gyro[0],
                        result.accel[2], result.accel[1], result.accel[0]};

endmodule
